// ----- sv/pcs_pkg.sv -----
package pcs_pkg;

  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  localparam int CNT_W    = $clog2(CHAN_W);

  localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(CHAN_W - 1);

  localparam logic ACT_MEASURE   = 1'b0;
  localparam logic ACT_NORMALIZE = 1'b1;

  typedef struct packed {
    logic              action;
    logic              frame_start;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_data_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              flat_flag;
  } out_data_t;

  typedef struct packed {
    logic start;
    logic normalize;
    logic restart;
  } lane_ctl_t;

  typedef struct packed {
    logic              busy;
    logic              flat;
    logic [CHAN_W-1:0] value;
  } lane_sts_t;

endpackage

// ----- sv/pcs_lane.sv -----
module pcs_lane
  import pcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lane_ctl_t         ctl_i,
  input  logic [CHAN_W-1:0] pix_i,
  output lane_sts_t         sts_o
);

  logic [CHAN_W-1:0] min_r;
  logic [CHAN_W-1:0] max_r;
  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              flat_r;
  logic [CHAN_W-1:0] q_r;
  logic [CHAN_W-1:0] rem_r;
  logic [CHAN_W-1:0] num_r;
  logic [CHAN_W-1:0] range_r;

  logic              flat_c;
  logic              below_c;
  logic              above_c;
  logic [CHAN_W-1:0] diff_c;
  logic [2*CHAN_W-1:0] num_c;
  logic [CHAN_W:0]   rem2_c;
  logic [CHAN_W:0]   sub_c;
  logic              take_c;

  // range check and scaled numerator (p - min) * max code
  assign flat_c  = (max_r <= min_r);
  assign below_c = (pix_i <= min_r);
  assign above_c = (pix_i >= max_r);
  assign diff_c  = pix_i - min_r;
  assign num_c   = {diff_c, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, diff_c};

  // one restoring division step per cycle
  assign rem2_c = {rem_r, num_r[CHAN_W-1]};
  assign sub_c  = rem2_c - {1'b0, range_r};
  assign take_c = (rem2_c >= {1'b0, range_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= CHAN_MAX;
      max_r  <= '0;
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl_i.start && ctl_i.normalize == ACT_MEASURE) begin
      if (ctl_i.restart) begin
        min_r <= pix_i;
        max_r <= pix_i;
      end else begin
        if (pix_i < min_r) min_r <= pix_i;
        if (pix_i > max_r) max_r <= pix_i;
      end
    end else if (ctl_i.start) begin
      cnt_r  <= '0;
      busy_r <= !(flat_c || below_c || above_c);
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.start && ctl_i.normalize == ACT_NORMALIZE) begin
      flat_r  <= flat_c;
      rem_r   <= num_c[2*CHAN_W-1:CHAN_W];
      num_r   <= num_c[CHAN_W-1:0];
      range_r <= max_r - min_r;
      if (flat_c || below_c) begin
        q_r <= '0;
      end else if (above_c) begin
        q_r <= CHAN_MAX;
      end else begin
        q_r <= '0;
      end
    end else if (busy_r) begin
      num_r <= {num_r[CHAN_W-2:0], 1'b0};
      if (take_c) begin
        rem_r <= sub_c[CHAN_W-1:0];
        q_r   <= {q_r[CHAN_W-2:0], 1'b1};
      end else begin
        rem_r <= rem2_c[CHAN_W-1:0];
        q_r   <= {q_r[CHAN_W-2:0], 1'b0};
      end
    end
  end

  assign sts_o.busy  = busy_r;
  assign sts_o.flat  = flat_r;
  assign sts_o.value = q_r;

endmodule

// ----- sv/per_channel_contrast_stretch_core.sv -----
// channel  ports                                 direction
// in       in_valid, in_ready, in_data           pixel requests in
// out      out_valid, out_ready, out_data        stretched pixels out
//
// a measure request does not leave IDLE, so in_ready stays high for the next request
// a normalize request runs an 8-step bit-serial divide in each colour lane,
// so in_ready stays low until the lanes finish and the result is loaded, even with no divide
// the result sits in an output register, so a new request is taken while it waits
// reset (rst_n, synchronous) sets min to all ones and max to zero per channel
// a stalled output holds the finished lanes until the register frees up
module per_channel_contrast_stretch_core
  import pcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_data_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t    state_r;
  logic      out_valid_r;
  out_data_t out_data_r;

  lane_ctl_t         lane_ctl;
  lane_sts_t         lane_sts [NUM_CHAN];
  logic [CHAN_W-1:0] lane_pix [NUM_CHAN];
  logic [NUM_CHAN-1:0] busy_vec;
  logic [NUM_CHAN-1:0] flat_vec;

  logic in_acc;
  logic load;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load     = (state_r == ST_RUN) && !(|busy_vec) && (!out_valid_r || out_ready);

  assign lane_ctl.start     = in_acc;
  assign lane_ctl.normalize = in_data.action;
  assign lane_ctl.restart   = in_data.frame_start;

  assign lane_pix[0] = in_data.red_in;
  assign lane_pix[1] = in_data.green_in;
  assign lane_pix[2] = in_data.blue_in;

  for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
    pcs_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (lane_ctl),
      .pix_i (lane_pix[g]),
      .sts_o (lane_sts[g])
    );
    assign busy_vec[g] = lane_sts[g].busy;
    assign flat_vec[g] = lane_sts[g].flat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_data.action == ACT_NORMALIZE) state_r <= ST_RUN;
        end
        ST_RUN: begin
          if (load) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // merge the lane results
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.red_out   <= lane_sts[0].value;
      out_data_r.green_out <= lane_sts[1].value;
      out_data_r.blue_out  <= lane_sts[2].value;
      out_data_r.flat_flag <= |flat_vec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_rise_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RUN))
    else $error("result appeared without a normalize in flight");

  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (|busy_vec) |-> (state_r == ST_RUN))
    else $error("lane dividing while control is idle");

  a_norm_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action == ACT_NORMALIZE) |=> (state_r == ST_RUN))
    else $error("normalize request did not start the lanes");

endmodule

// ----- dv/per_channel_contrast_stretch_core_tb.sv -----
`timescale 1ns / 100ps

module per_channel_contrast_stretch_core_tb;
  import pcs_pkg::*;

  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned PRINT_CAP    = 50;
  localparam int unsigned PIX_MAX      = 32'(CHAN_MAX);

  class pixel_scoreboard;
    logic [CHAN_W-1:0] chan_lo[NUM_CHAN];
    logic [CHAN_W-1:0] chan_hi[NUM_CHAN];
    out_data_t         stretched_q[$];
    int unsigned       mismatches;

    function new();
      for (int c = 0; c < NUM_CHAN; c++) begin
        chan_lo[c] = CHAN_MAX;
        chan_hi[c] = '0;
      end
      mismatches = 0;
    endfunction

    // empty or inverted range reads as flat
    function logic [CHAN_W-1:0] stretch_code(logic [CHAN_W-1:0] p, logic [CHAN_W-1:0] lo,
                                             logic [CHAN_W-1:0] hi, inout bit flat);
      int unsigned num;
      int unsigned den;
      int unsigned q;
      if (hi <= lo) begin
        flat = 1'b1;
        return '0;
      end
      if (p <= lo) return '0;
      if (p >= hi) return CHAN_MAX;
      num = 32'(p) - 32'(lo);
      den = 32'(hi) - 32'(lo);
      q = (num * PIX_MAX) / den;
      if (q > PIX_MAX) q = PIX_MAX;
      return q[CHAN_W-1:0];
    endfunction

    function void note_request(in_data_t req);
      logic [CHAN_W-1:0] px[NUM_CHAN];
      logic [CHAN_W-1:0] res[NUM_CHAN];
      out_data_t         want;
      bit                flat;
      px[0] = req.red_in;
      px[1] = req.green_in;
      px[2] = req.blue_in;
      if (req.action == ACT_MEASURE) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          if (req.frame_start) begin
            chan_lo[c] = px[c];
            chan_hi[c] = px[c];
          end else begin
            if (px[c] < chan_lo[c]) chan_lo[c] = px[c];
            if (px[c] > chan_hi[c]) chan_hi[c] = px[c];
          end
        end
      end else begin
        flat = 1'b0;
        for (int c = 0; c < NUM_CHAN; c++)
          res[c] = stretch_code(px[c], chan_lo[c], chan_hi[c], flat);
        want.red_out   = res[0];
        want.green_out = res[1];
        want.blue_out  = res[2];
        want.flat_flag = flat;
        stretched_q.insert(stretched_q.size(), want);
      end
    endfunction

    task report(string msg);
      if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_pixel(out_data_t got);
      out_data_t want;
      if (stretched_q.size() == 0) begin
        report($sformatf("pixel %h with no request waiting", got));
        return;
      end
      want = stretched_q.pop_front();
      if (got.red_out !== want.red_out)
        report($sformatf("red_out got %0d want %0d", got.red_out, want.red_out));
      if (got.green_out !== want.green_out)
        report($sformatf("green_out got %0d want %0d", got.green_out, want.green_out));
      if (got.blue_out !== want.blue_out)
        report($sformatf("blue_out got %0d want %0d", got.blue_out, want.blue_out));
      if (got.flat_flag !== want.flat_flag)
        report($sformatf("flat_flag got %0b want %0b", got.flat_flag, want.flat_flag));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_data_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_data_t out_data;

  pixel_scoreboard sb = new();

  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_cnt = 0;
  int unsigned quiet_cycles = 0;

  per_channel_contrast_stretch_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // result side: random stalls, plus a long hold-off when asked for
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_pixel(out_data);
    if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cnt  <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("per_channel_contrast_stretch_core_tb NOT OK");
      $finish;
    end
  end

  function automatic in_data_t pixel_req(logic act, logic fs, int unsigned r,
                                         int unsigned g, int unsigned b);
    in_data_t req;
    req.action      = act;
    req.frame_start = fs;
    req.red_in      = CHAN_W'(r);
    req.green_in    = CHAN_W'(g);
    req.blue_in     = CHAN_W'(b);
    return req;
  endfunction

  function automatic in_data_t random_pixel(logic act, logic fs);
    return pixel_req(act, fs, $urandom_range(PIX_MAX), $urandom_range(PIX_MAX),
                     $urandom_range(PIX_MAX));
  endfunction

  function automatic in_data_t band_pixel(logic act, logic fs, int unsigned lo[NUM_CHAN],
                                          int unsigned span[NUM_CHAN]);
    return pixel_req(act, fs, lo[0] + $urandom_range(span[0]),
                     lo[1] + $urandom_range(span[1]), lo[2] + $urandom_range(span[2]));
  endfunction

  task automatic send_pixel(in_data_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
  endtask

  // measure a frame, then stretch pixels against it; some noise and broken frames
  task automatic run_frames(int unsigned quota);
    int unsigned done_n;
    int unsigned style;
    int unsigned n_meas;
    int unsigned n_norm;
    int unsigned flat_chan;
    int unsigned lo[NUM_CHAN];
    int unsigned span[NUM_CHAN];
    done_n = 0;
    while (done_n < quota) begin
      if ($urandom_range(99) < 12) begin
        send_pixel(random_pixel(1'($urandom_range(1)), 1'($urandom_range(1))));
        done_n++;
      end else begin
        style = $urandom_range(3);
        flat_chan = $urandom_range(NUM_CHAN - 1);
        for (int c = 0; c < NUM_CHAN; c++) begin
          case (style)
            0: span[c] = PIX_MAX;
            1: span[c] = $urandom_range(40);
            2: span[c] = (c == flat_chan) ? 0 : $urandom_range(PIX_MAX);
            default: span[c] = 0;
          endcase
          lo[c] = $urandom_range(PIX_MAX - span[c]);
        end
        n_meas = (style == 3) ? 0 : $urandom_range(1, 6);
        n_norm = $urandom_range(1, 6);
        // a missing frame start keeps the old statistics in play
        send_pixel(band_pixel(ACT_MEASURE, $urandom_range(99) >= 8, lo, span));
        repeat (n_meas) send_pixel(band_pixel(ACT_MEASURE, 1'b0, lo, span));
        repeat (n_norm) begin
          if ($urandom_range(99) < 70)
            send_pixel(band_pixel(ACT_NORMALIZE, 1'($urandom_range(1)), lo, span));
          else
            send_pixel(random_pixel(ACT_NORMALIZE, 1'($urandom_range(1))));
        end
        done_n += 1 + n_meas + n_norm;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 16;
    out_idle_pct <= 64;

    // nothing measured yet: every channel reads as flat
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, 0, 0, 0));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b1, PIX_MAX, 128, 0));
    // first measure without frame start sets min and max from reset values
    send_pixel(pixel_req(ACT_MEASURE, 1'b0, 10, 200, 0));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, 10, 200, 0));
    send_pixel(pixel_req(ACT_MEASURE, 1'b0, 250, 100, PIX_MAX));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, 0, PIX_MAX, 128));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, 130, 150, PIX_MAX));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, 10, 100, 0));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, 250, 200, PIX_MAX));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b1, 11, 199, 1));
    send_pixel(pixel_req(ACT_MEASURE, 1'b1, 0, PIX_MAX, 77));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, 0, PIX_MAX, 77));
    send_pixel(pixel_req(ACT_MEASURE, 1'b0, PIX_MAX, 0, 77));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, 1, 254, 200));
    // range of one code
    send_pixel(pixel_req(ACT_MEASURE, 1'b1, 100, 100, 100));
    send_pixel(pixel_req(ACT_MEASURE, 1'b0, 101, 101, 101));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, 100, 101, PIX_MAX));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, 101, 100, 0));
    send_pixel(pixel_req(ACT_MEASURE, 1'b1, 0, 0, 0));
    send_pixel(pixel_req(ACT_MEASURE, 1'b0, PIX_MAX, PIX_MAX, PIX_MAX));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, PIX_MAX, 0, 170));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b0, 1, 254, 85));
    send_pixel(pixel_req(ACT_NORMALIZE, 1'b1, 127, 128, 129));

    run_frames(370);

    // back up the output while requests keep coming
    hold_req <= hold_req + 1;
    in_idle_pct = 0;
    send_pixel(random_pixel(ACT_MEASURE, 1'b1));
    repeat (3) send_pixel(random_pixel(ACT_MEASURE, 1'b0));
    repeat (24) send_pixel(random_pixel(ACT_NORMALIZE, 1'($urandom_range(1))));

    // let everything drain before carrying on
    in_valid <= 1'b0;
    while (sb.stretched_q.size() != 0) @(posedge clk);

    in_idle_pct = 64;
    out_idle_pct <= 16;
    run_frames(370);

    in_idle_pct = 0;
    out_idle_pct <= 0;
    run_frames(370);

    in_valid <= 1'b0;
    while (sb.stretched_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0)
      $display("per_channel_contrast_stretch_core_tb OK");
    else
      $display("per_channel_contrast_stretch_core_tb NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
sv/pcs_pkg.sv
sv/pcs_lane.sv
sv/per_channel_contrast_stretch_core.sv
dv/per_channel_contrast_stretch_core_tb.sv
